// ----- design/edf_pkg.sv -----
// Shared types and constants for the EDF task scheduler.
// No dependencies; imported by every module of the block.
package edf_pkg;
   localparam int MaxTasks  = 16;
   localparam int TimeWidth = 32;
   localparam int SlotW     = $clog2(MaxTasks);
   localparam int CountW    = $clog2(MaxTasks + 1);

   localparam logic [1:0] CMD_TICK   = 2'd0;
   localparam logic [1:0] CMD_CREATE = 2'd1;
   localparam logic [1:0] CMD_SWITCH = 2'd2;
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   typedef logic [SlotW-1:0]     slot_type;
   typedef logic [CountW-1:0]    count_type;
   typedef logic [TimeWidth-1:0] time_type;

   // controller -> datapath
   typedef struct packed {
      logic load;        // capture input beat, clear result flags
      logic tick;        // advance clock
      logic find_free;   // search free slot, claim, queue it
      logic finish;      // requeue or retire running task
      logic rt_scan;     // examine one rt list entry (index scan_idx)
      logic rt_shift;    // remove entry at scan_idx, shift the tail
      logic fifo_pop;    // dispatch fifo head
      logic set_wait;
      logic set_none;
      logic clr_wait;
      logic clr_run;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic      wait_flag;
      logic      scan_hit;   // entry at scan_idx released
      logic      scan_end;   // scan_idx reached rt_count
      logic      fifo_nz;
      logic      rt_nz;
      logic      ins_busy;   // rt insertion (search or shift) in progress
      logic      shift_busy; // removal shift in progress
   } status_type;
endpackage

// ----- design/edf_datapath.sv -----
// Datapath of the EDF scheduler: clock, slot table, sorted rt list, fifo.
// Depends on edf_pkg; driven by edf_control through cmd_type.
module edf_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  edf_pkg::cmd_type      cmd,
   input  logic                  in_rt,
   input  logic [23:0]           in_start,
   input  logic [23:0]           in_deadline,
   input  logic                  in_still,
   output edf_pkg::status_type   status,
   output logic                  o_dispatch,
   output logic [3:0]            o_slot,
   output logic                  o_is_rt,
   output logic                  o_fail,
   output logic                  o_wait,
   output logic                  o_none,
   output logic [15:0]           o_met,
   output logic [15:0]           o_miss,
   output logic [31:0]           o_now
);
   import edf_pkg::*;

   time_type  clock_ff, clock_in;
   logic [MaxTasks-1:0] used_ff, used_in;
   logic [MaxTasks-1:0] rtf_ff, rtf_in;
   time_type  rel_ff [MaxTasks];
   time_type  due_ff [MaxTasks];
   slot_type  order_ff [MaxTasks];
   slot_type  fifo_ff [MaxTasks];
   count_type rtc_ff, rtc_in;
   slot_type  head_ff, head_in;
   count_type fc_ff, fc_in;
   slot_type  run_ff, run_in;
   logic      runv_ff, runv_in;
   logic      wait_ff, wait_in;
   logic [15:0] met_ff, met_in, miss_ff, miss_in;
   count_type scan_ff, scan_in;
   // insertion: walk pos upward; shift one entry per cycle from the tail
   logic      ins_ff, ins_in;
   count_type ipos_ff, ipos_in;
   count_type ik_ff, ik_in;
   logic      isrch_ff, isrch_in;
   slot_type  islot_ff, islot_in;
   logic      shf_ff, shf_in;
   logic      disp_ff, disp_in, isrt_ff, isrt_in, fail_ff, fail_in;
   logic      ow_ff, ow_in, on_ff, on_in;
   slot_type  oslot_ff, oslot_in;

   logic      free_found;
   slot_type  free_slot;
   time_type  rel_new, due_new;
   logic      wr_slot;
   logic      ord_wr;
   slot_type  ord_idx, ord_val;
   logic      fifo_wr;
   slot_type  fifo_idx, fifo_val;
   logic      ins_start;
   slot_type  ins_start_slot;

   always_comb begin
      free_found = 1'b0;
      free_slot  = '0;
      for (int i = MaxTasks - 1; i >= 0; i--) begin
         if (!used_ff[i]) begin
            free_found = 1'b1;
            free_slot  = slot_type'(i);
         end
      end
   end

   assign rel_new = clock_ff + time_type'(in_start);
   assign due_new = rel_new + time_type'(in_deadline);

   always_comb begin
      clock_in = clock_ff;  used_in = used_ff;  rtf_in = rtf_ff;
      rtc_in = rtc_ff;  head_in = head_ff;  fc_in = fc_ff;
      run_in = run_ff;  runv_in = runv_ff;  wait_in = wait_ff;
      met_in = met_ff;  miss_in = miss_ff;  scan_in = scan_ff;
      ins_in = ins_ff;  ipos_in = ipos_ff;  ik_in = ik_ff;
      isrch_in = isrch_ff;  islot_in = islot_ff;  shf_in = shf_ff;
      disp_in = disp_ff;  isrt_in = isrt_ff;  fail_in = fail_ff;
      ow_in = ow_ff;  on_in = on_ff;  oslot_in = oslot_ff;
      wr_slot = 1'b0;  ord_wr = 1'b0;  ord_idx = '0;  ord_val = '0;
      fifo_wr = 1'b0;  fifo_idx = '0;  fifo_val = '0;
      ins_start = 1'b0;  ins_start_slot = '0;

      if (cmd.load) begin
         disp_in = 1'b0; isrt_in = 1'b0; fail_in = 1'b0;
         ow_in = 1'b0; on_in = 1'b0; oslot_in = '0; scan_in = '0;
      end
      if (cmd.tick) clock_in = clock_ff + time_type'(1);
      if (cmd.find_free) begin
         if (!free_found) begin
            fail_in = 1'b1;
         end else begin
            used_in[free_slot] = 1'b1;
            oslot_in = free_slot;
            wr_slot = 1'b1;
            rtf_in[free_slot] = in_rt;
            if (in_rt) begin
               ins_start = 1'b1;
               ins_start_slot = free_slot;
            end else if (fc_ff < count_type'(MaxTasks)) begin
               fifo_wr = 1'b1;
               fifo_idx = head_ff + slot_type'(fc_ff);
               fifo_val = free_slot;
               fc_in = fc_ff + count_type'(1);
            end
         end
      end
      if (cmd.finish) begin
         if (runv_ff) begin
            if (in_still) begin
               if (rtf_ff[run_ff]) begin
                  ins_start = 1'b1;
                  ins_start_slot = run_ff;
               end else if (fc_ff < count_type'(MaxTasks)) begin
                  fifo_wr = 1'b1;
                  fifo_idx = head_ff + slot_type'(fc_ff);
                  fifo_val = run_ff;
                  fc_in = fc_ff + count_type'(1);
               end
            end else begin
               if (rtf_ff[run_ff]) begin
                  if (clock_ff <= due_ff[run_ff]) begin
                     if (met_ff != 16'hFFFF) met_in = met_ff + 16'd1;
                  end else if (miss_ff != 16'hFFFF) begin
                     miss_in = miss_ff + 16'd1;
                  end
               end
               used_in[run_ff] = 1'b0;
            end
         end
      end
      if (cmd.clr_run) runv_in = 1'b0;
      if (ins_start && rtc_ff < count_type'(MaxTasks)) begin
         ins_in = 1'b1; isrch_in = 1'b1; ipos_in = '0;
         islot_in = ins_start_slot;
      end
      // insertion engine: search phase then one shift per cycle
      if (ins_ff) begin
         if (isrch_ff) begin
            if (ipos_ff < rtc_ff &&
                due_ff[order_ff[ipos_ff[SlotW-1:0]]] <= due_ff[islot_ff]) begin
               ipos_in = ipos_ff + count_type'(1);
            end else begin
               isrch_in = 1'b0;
               ik_in = rtc_ff;
            end
         end else if (ik_ff > ipos_ff) begin
            ord_wr = 1'b1;
            ord_idx = ik_ff[SlotW-1:0];
            ord_val = order_ff[ik_ff[SlotW-1:0] - slot_type'(1)];
            ik_in = ik_ff - count_type'(1);
         end else begin
            ord_wr = 1'b1;
            ord_idx = ipos_ff[SlotW-1:0];
            ord_val = islot_ff;
            rtc_in = rtc_ff + count_type'(1);
            ins_in = 1'b0;
         end
      end
      if (cmd.rt_scan && !status.scan_hit) scan_in = scan_ff + count_type'(1);
      if (cmd.rt_shift) begin
         run_in = order_ff[scan_ff[SlotW-1:0]];
         runv_in = 1'b1;
         disp_in = 1'b1; isrt_in = 1'b1;
         oslot_in = order_ff[scan_ff[SlotW-1:0]];
         wait_in = 1'b0;
         shf_in = 1'b1;
      end
      if (shf_ff) begin
         if (scan_ff + count_type'(1) < rtc_ff) begin
            ord_wr = 1'b1;
            ord_idx = scan_ff[SlotW-1:0];
            ord_val = order_ff[scan_ff[SlotW-1:0] + slot_type'(1)];
            scan_in = scan_ff + count_type'(1);
         end else begin
            rtc_in = rtc_ff - count_type'(1);
            shf_in = 1'b0;
         end
      end
      if (cmd.fifo_pop) begin
         run_in = fifo_ff[head_ff];
         runv_in = 1'b1;
         disp_in = 1'b1; isrt_in = 1'b0;
         oslot_in = fifo_ff[head_ff];
         head_in = head_ff + slot_type'(1);
         fc_in = fc_ff - count_type'(1);
         wait_in = 1'b0;
      end
      if (cmd.set_wait) begin wait_in = 1'b1; ow_in = 1'b1; end
      if (cmd.set_none) begin wait_in = 1'b0; on_in = 1'b1; end
      if (cmd.clr_wait) wait_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clock_ff <= '0; used_ff <= '0; rtc_ff <= '0; head_ff <= '0;
         fc_ff <= '0; run_ff <= '0; runv_ff <= 1'b0; wait_ff <= 1'b0;
         met_ff <= '0; miss_ff <= '0; ins_ff <= 1'b0; shf_ff <= 1'b0;
         isrch_ff <= 1'b0;
      end else begin
         clock_ff <= clock_in; used_ff <= used_in; rtc_ff <= rtc_in;
         head_ff <= head_in; fc_ff <= fc_in; run_ff <= run_in;
         runv_ff <= runv_in; wait_ff <= wait_in; met_ff <= met_in;
         miss_ff <= miss_in; ins_ff <= ins_in; shf_ff <= shf_in;
         isrch_ff <= isrch_in;
      end
   end

   always_ff @(posedge clock) begin
      rtf_ff <= rtf_in; scan_ff <= scan_in; ipos_ff <= ipos_in; ik_ff <= ik_in;
      islot_ff <= islot_in; disp_ff <= disp_in; isrt_ff <= isrt_in;
      fail_ff <= fail_in; ow_ff <= ow_in; on_ff <= on_in; oslot_ff <= oslot_in;
      if (wr_slot) begin
         rel_ff[free_slot] <= in_rt ? rel_new : '0;
         due_ff[free_slot] <= in_rt ? due_new : '0;
      end
      if (ord_wr) order_ff[ord_idx] <= ord_val;
      if (fifo_wr) fifo_ff[fifo_idx] <= fifo_val;
   end

   always_comb begin
      status.wait_flag  = wait_ff;
      status.scan_end   = (scan_ff >= rtc_ff);
      status.scan_hit   = !status.scan_end &&
                          (rel_ff[order_ff[scan_ff[SlotW-1:0]]] <= clock_ff);
      status.fifo_nz    = (fc_ff != '0);
      status.rt_nz      = (rtc_ff != '0);
      status.ins_busy   = ins_ff;
      status.shift_busy = shf_ff;
   end

   assign o_dispatch = disp_ff;
   assign o_slot     = 4'(oslot_ff);
   assign o_is_rt    = isrt_ff;
   assign o_fail     = fail_ff;
   assign o_wait     = ow_ff;
   assign o_none     = on_ff;
   assign o_met      = met_ff;
   assign o_miss     = miss_ff;
   assign o_now      = clock_ff[31:0];
endmodule

// ----- design/edf_control.sv -----
// Sequencer of the EDF scheduler: steps one event through the datapath.
// Depends on edf_pkg; commands edf_datapath, owns the channel handshake.
module edf_control (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [1:0]           req_cmd,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  edf_pkg::status_type  status,
   output edf_pkg::cmd_type     cmd
);
   import edf_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_EXEC  = 3'd1;
   localparam logic [2:0] ST_INS   = 3'd2;
   localparam logic [2:0] ST_SCAN  = 3'd3;
   localparam logic [2:0] ST_SHIFT = 3'd4;
   localparam logic [2:0] ST_OUT   = 3'd5;

   logic [2:0] state_ff, state_in;
   logic [1:0] op_ff, op_in;
   logic       wasw_ff, wasw_in;
   logic       vld_ff, vld_in;

   assign req_stall = (state_ff != ST_IDLE) || vld_ff;
   assign rsp_valid = vld_ff;

   always_comb begin
      state_in = state_ff; op_in = op_ff; wasw_in = wasw_ff;
      vld_in = vld_ff && rsp_stall;
      cmd = '0;
      case (state_ff)
         ST_IDLE: if (req_valid && !req_stall) begin
            cmd.load = 1'b1;
            op_in = req_cmd;
            wasw_in = status.wait_flag;
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            case (op_ff)
               CMD_TICK: begin
                  cmd.tick = 1'b1;
                  state_in = wasw_ff ? ST_SCAN : ST_OUT;
               end
               CMD_CREATE: begin
                  cmd.find_free = 1'b1;
                  state_in = ST_INS;
               end
               CMD_SWITCH: begin
                  if (!wasw_ff) cmd.finish = 1'b1;
                  cmd.clr_run = 1'b1;
                  state_in = ST_INS;
               end
               default: state_in = ST_OUT;
            endcase
         end
         ST_INS: if (!status.ins_busy) begin
            state_in = (op_ff == CMD_SWITCH) ? ST_SCAN : ST_OUT;
         end
         ST_SCAN: begin
            cmd.rt_scan = 1'b1;
            if (status.scan_hit) begin
               cmd.rt_shift = 1'b1;
               state_in = ST_SHIFT;
            end else if (status.scan_end) begin
               if (status.fifo_nz) cmd.fifo_pop = 1'b1;
               else if (status.rt_nz) cmd.set_wait = 1'b1;
               else cmd.set_none = 1'b1;
               state_in = ST_OUT;
            end
         end
         ST_SHIFT: if (!status.shift_busy) state_in = ST_OUT;
         ST_OUT: begin
            vld_in = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; vld_ff <= 1'b0;
      end else begin
         state_ff <= state_in; vld_ff <= vld_in;
      end
   end
   always_ff @(posedge clock) begin
      op_ff <= op_in; wasw_ff <= wasw_in;
   end
endmodule

// ----- design/edf_task_scheduler.sv -----
// EDF task scheduler with a background FIFO: top level.
// Each event is stepped by edf_control: a create queues the new task, a tick that was
// waiting retries dispatch, and a switch requeues or retires the running task and scans.
// One event at a time: the next beat is taken only once the result has been taken.
// Reset (synchronous, active high) clears clock, counters, queues and slot use.
module edf_task_scheduler (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  logic [1:0]   req_cmd,
   input  logic         req_is_realtime,
   input  logic [23:0]  req_start_offset_ms,
   input  logic [23:0]  req_deadline_offset_ms,
   input  logic         req_still_running,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output logic         rsp_dispatch_valid,
   output logic [3:0]   rsp_task_slot,
   output logic         rsp_task_is_realtime,
   output logic         rsp_create_failed,
   output logic         rsp_waiting,
   output logic         rsp_none_left,
   output logic [15:0]  rsp_met_count,
   output logic [15:0]  rsp_miss_count,
   output logic [31:0]  rsp_now_ms
);
   import edf_pkg::*;

   cmd_type    cmd;
   status_type status;
   // input beat captured at accept; payload of the request holds while
   // stalled, but the event runs after accept, so latch the fields
   logic        rt_ff;
   logic [23:0] st_ff, dl_ff;
   logic        still_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rt_ff <= req_is_realtime; st_ff <= req_start_offset_ms;
         dl_ff <= req_deadline_offset_ms; still_ff <= req_still_running;
      end
   end

   edf_control u_ctl (
      .clock, .reset, .req_valid, .req_stall, .req_cmd,
      .rsp_valid, .rsp_stall, .status, .cmd
   );

   edf_datapath u_dp (
      .clock, .reset, .cmd,
      .in_rt(rt_ff), .in_start(st_ff), .in_deadline(dl_ff),
      .in_still(still_ff), .status,
      .o_dispatch(rsp_dispatch_valid), .o_slot(rsp_task_slot),
      .o_is_rt(rsp_task_is_realtime), .o_fail(rsp_create_failed),
      .o_wait(rsp_waiting), .o_none(rsp_none_left),
      .o_met(rsp_met_count), .o_miss(rsp_miss_count), .o_now(rsp_now_ms)
   );

   // outcome flags of one beat are exclusive
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot0({rsp_dispatch_valid, rsp_create_failed,
                              rsp_waiting, rsp_none_left}))
      else $error("conflicting outcome flags");
   // no new event while a result is still pending
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("accept while result pending");
   // met count never decreases
   assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> rsp_met_count >= $past(rsp_met_count))
      else $error("met count decreased");
endmodule

// ----- tb/edf_task_scheduler_checker.sv -----
// Scoreboard for the EDF task scheduler: watches both channels, predicts each result beat.
// Depends on edf_pkg for command codes, slot and time types.
module edf_task_scheduler_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [1:0]  req_cmd,
   input  logic        req_is_realtime,
   input  logic [23:0] req_start_offset_ms,
   input  logic [23:0] req_deadline_offset_ms,
   input  logic        req_still_running,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic        rsp_dispatch_valid,
   input  logic [3:0]  rsp_task_slot,
   input  logic        rsp_task_is_realtime,
   input  logic        rsp_create_failed,
   input  logic        rsp_waiting,
   input  logic        rsp_none_left,
   input  logic [15:0] rsp_met_count,
   input  logic [15:0] rsp_miss_count,
   input  logic [31:0] rsp_now_ms,
   output int          fail_count,
   output int          pending_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import edf_pkg::*;

   typedef struct packed {
      logic        dispatched;
      logic [3:0]  slot;
      logic        rt;
      logic        create_failed;
      logic        waiting;
      logic        none_left;
      logic [15:0] met;
      logic [15:0] miss;
      logic [31:0] now;
   } sched_result_type;

   time_type         now_ms;
   logic             used [MaxTasks];
   logic             is_rt [MaxTasks];
   time_type         release_at [MaxTasks];
   time_type         due_at [MaxTasks];
   slot_type         edf_list [$];
   slot_type         bg_fifo [$];
   slot_type         run_slot;
   logic             run_valid;
   logic             idle_wait;
   logic [15:0]      met_total, miss_total;
   sched_result_type expected_beats [$];

   assign pending_count = expected_beats.size();

   function automatic void edf_insert(slot_type s);
      int pos;
      pos = 0;
      while (pos < edf_list.size() && due_at[edf_list[pos]] <= due_at[s]) pos++;
      edf_list.insert(pos, s);
   endfunction

   function automatic void pick_next(ref sched_result_type r);
      idle_wait = 0;
      foreach (edf_list[i]) begin
         if (release_at[edf_list[i]] <= now_ms) begin
            run_slot = edf_list[i];
            edf_list.delete(i);
            run_valid = 1;
            r.dispatched = 1; r.slot = run_slot; r.rt = 1;
            return;
         end
      end
      if (bg_fifo.size() > 0) begin
         run_slot = bg_fifo.pop_front();
         run_valid = 1;
         r.dispatched = 1; r.slot = run_slot; r.rt = 0;
         return;
      end
      if (edf_list.size() > 0) begin
         idle_wait = 1;
         r.waiting = 1;
         return;
      end
      r.none_left = 1;
   endfunction

   function automatic sched_result_type predict_event(logic [1:0] cmd, logic rt,
         logic [23:0] start_off, logic [23:0] due_off, logic keep);
      sched_result_type r;
      int s;
      r = '0;
      case (cmd)
         CMD_TICK: begin
            now_ms++;
            if (idle_wait) pick_next(r);
         end
         CMD_CREATE: begin
            s = 0;
            while (s < MaxTasks && used[s]) s++;
            if (s >= MaxTasks) r.create_failed = 1;
            else begin
               used[s] = 1;
               r.slot = 4'(s);
               is_rt[s] = rt;
               if (rt) begin
                  release_at[s] = now_ms + start_off;
                  due_at[s] = release_at[s] + due_off;
                  edf_insert(slot_type'(s));
               end else bg_fifo.push_back(slot_type'(s));
            end
         end
         CMD_SWITCH: begin
            if (run_valid) begin
               if (keep) begin
                  if (is_rt[run_slot]) edf_insert(run_slot);
                  else bg_fifo.push_back(run_slot);
               end else begin
                  if (is_rt[run_slot]) begin
                     if (now_ms <= due_at[run_slot]) begin
                        if (met_total != 16'hFFFF) met_total++;
                     end else if (miss_total != 16'hFFFF) miss_total++;
                  end
                  used[run_slot] = 0;
               end
            end
            run_valid = 0;
            pick_next(r);
         end
         default: ;
      endcase
      r.met = met_total;
      r.miss = miss_total;
      r.now = now_ms;
      return r;
   endfunction

   always @(posedge clock) begin
      sched_result_type got, exp_r;
      if (reset) begin
         now_ms = '0; run_slot = '0; run_valid = 0; idle_wait = 0;
         met_total = '0; miss_total = '0;
         edf_list.delete(); bg_fifo.delete(); expected_beats.delete();
         foreach (used[i]) used[i] = 0;
         fail_count <= 0;
      end else begin
         if (req_valid && !req_stall)
            expected_beats.push_back(predict_event(req_cmd, req_is_realtime,
               req_start_offset_ms, req_deadline_offset_ms, req_still_running));
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_dispatch_valid, rsp_task_slot, rsp_task_is_realtime,
                   rsp_create_failed, rsp_waiting, rsp_none_left,
                   rsp_met_count, rsp_miss_count, rsp_now_ms};
            if (expected_beats.size() == 0) begin
               $display("%0t: unexpected beat, expected none actual %h", $time, got);
               fail_count <= fail_count + 1;
            end else begin
               exp_r = expected_beats.pop_front();
               if (got !== exp_r) begin
                  $display("%0t: mismatch expected %p actual %p", $time, exp_r, got);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end
endmodule

// ----- tb/edf_task_scheduler_tb.sv -----
// Testbench top for the EDF task scheduler: clock, reset, stimulus and verdict.
// Depends on edf_pkg, edf_task_scheduler and edf_task_scheduler_checker.
module edf_task_scheduler_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import edf_pkg::*;

   localparam int WatchdogLimit = 20000;

   logic        clock, reset;
   logic        req_valid, req_stall;
   logic [1:0]  req_cmd;
   logic        req_is_realtime, req_still_running;
   logic [23:0] req_start_offset_ms, req_deadline_offset_ms;
   logic        rsp_valid, rsp_stall;
   logic        rsp_dispatch_valid, rsp_task_is_realtime;
   logic        rsp_create_failed, rsp_waiting, rsp_none_left;
   logic [3:0]  rsp_task_slot;
   logic [15:0] rsp_met_count, rsp_miss_count;
   logic [31:0] rsp_now_ms;
   int          fail_count, pending_count;

   // Idle rates in percent; stall_hold forces a long receiver hold-off.
   int          send_idle_pct, recv_idle_pct;
   logic        stall_hold;
   int          idle_cycles;

   edf_task_scheduler dut (.*);
   edf_task_scheduler_checker checker_inst (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // Receiver: stall at random, or hold off entirely while stall_hold is set.
   always @(posedge clock)
      rsp_stall <= stall_hold || ($urandom_range(99) < recv_idle_pct);

   // Watchdog: count cycles in which no beat moves on either channel.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
         $display("tb: failure");
         $finish;
      end
   end

   // Send one beat: offer it (after an optional idle gap) and hold until accepted.
   task automatic send_event(logic [1:0] cmd, logic rt, logic [23:0] start_off,
         logic [23:0] due_off, logic keep);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_cmd <= cmd;
      req_is_realtime <= rt;
      req_start_offset_ms <= start_off;
      req_deadline_offset_ms <= due_off;
      req_still_running <= keep;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // Mostly small offsets so releases and deadlines fall inside the run,
   // now and then the full 24-bit range.
   function automatic logic [23:0] pick_offset();
      case ($urandom_range(9))
         0: return 24'($urandom);
         1: return 24'hFFFFFF;
         2: return 24'd0;
         default: return 24'($urandom_range(40));
      endcase
   endfunction

   task automatic random_event();
      int sel;
      logic [1:0] cmd;
      sel = $urandom_range(99);
      if (sel < 40) cmd = CMD_TICK;
      else if (sel < 65) cmd = CMD_CREATE;
      else if (sel < 98) cmd = CMD_SWITCH;
      else cmd = CMD_UNUSED;
      send_event(cmd, 1'($urandom_range(1)), pick_offset(), pick_offset(),
                 1'($urandom_range(1)));
   endtask

   task automatic drain();
      req_valid <= 0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   initial begin
      req_valid = 0; req_cmd = CMD_TICK; req_is_realtime = 0;
      req_start_offset_ms = 0; req_deadline_offset_ms = 0; req_still_running = 0;
      stall_hold = 0; send_idle_pct = 0; recv_idle_pct = 0;
      reset = 1;
      repeat (3) @(posedge clock);
      reset <= 0;

      // Directed: empty switch, unknown command, extremes, overfill, wait, met and missed.
      send_event(CMD_SWITCH, 0, 0, 0, 1);
      send_event(CMD_UNUSED, 1, 24'hFFFFFF, 24'hFFFFFF, 1);
      send_event(CMD_CREATE, 1, 24'd3, 24'd0, 0);
      send_event(CMD_SWITCH, 0, 0, 0, 0);       // waiting for release
      send_event(CMD_CREATE, 0, 24'hFFFFFF, 24'hFFFFFF, 0); // queued while waiting
      send_event(CMD_TICK, 0, 0, 0, 0);         // background runs
      send_event(CMD_SWITCH, 0, 0, 0, 0);
      send_event(CMD_TICK, 0, 0, 0, 0);
      send_event(CMD_TICK, 0, 0, 0, 0);
      send_event(CMD_TICK, 0, 0, 0, 0);
      send_event(CMD_TICK, 0, 0, 0, 0);
      send_event(CMD_SWITCH, 0, 0, 0, 1);       // rt dispatched, requeue
      send_event(CMD_TICK, 0, 0, 0, 0);
      send_event(CMD_SWITCH, 0, 0, 0, 0);       // finish late: missed
      send_event(CMD_CREATE, 1, 24'd0, 24'hFFFFFF, 0);
      send_event(CMD_SWITCH, 0, 0, 0, 0);
      send_event(CMD_SWITCH, 0, 0, 0, 0);       // met
      for (int i = 0; i < 17; i++)              // seventeenth create fails
         send_event(CMD_CREATE, i[0], 24'hFFFFFF, 24'(i), 0);
      drain();

      // Receiver holds off while the sender keeps offering.
      stall_hold = 1;
      fork
         repeat (10) random_event();
         begin
            repeat (300) @(posedge clock);
            stall_hold = 0;
         end
      join
      for (int i = 0; i < 20; i++) send_event(CMD_SWITCH, 0, 0, 0, 0);

      send_idle_pct = 7; recv_idle_pct = 71;
      repeat (300) random_event();
      send_idle_pct = 71; recv_idle_pct = 7;
      repeat (300) random_event();
      send_idle_pct = 0; recv_idle_pct = 0;
      repeat (300) random_event();
      drain();

      if (fail_count == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end
endmodule
